// ----- rtl/core/indexed_list_engine_assert.svh -----
// Assertion macros for the indexed list engine.
// Each macro expects clk and rst_n in scope; checks are off while in reset.
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

// cond must never be true
`define ILE_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("%m: assertion failed");

// ante implies cons in the same cycle
`define ILE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// ante implies cons in the next cycle
`define ILE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- rtl/core/ile_pkg.sv -----
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and constants of the indexed list engine: command codes,
// status codes, field widths and store control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ile_pkg;

  localparam int ILE_CAPACITY   = 16;
  localparam int ILE_DATA_WIDTH = 32;

  localparam int KIND_W   = 4;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 4'd0,
    KIND_PUSH_BACK  = 4'd1,
    KIND_INSERT     = 4'd2,
    KIND_ERASE      = 4'd3,
    KIND_POP_FRONT  = 4'd4,
    KIND_POP_BACK   = 4'd5,
    KIND_READ       = 4'd6,
    KIND_READ_FRONT = 4'd7,
    KIND_READ_BACK  = 4'd8,
    KIND_CLEAR      = 4'd9
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Store update for one transaction: open a slot or close one at the index
  typedef struct packed {
    logic ins;
    logic del;
  } store_ctl_t;

endpackage

// ----- rtl/core/ile_store.sv -----
// ----------------------------------------------------------------------------
// ile_store
// Register array of list entries. Insert shifts the tail up by one slot,
// erase shifts it down, all entries in parallel; one read port by index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ile_store
  import ile_pkg::*;
#(
  parameter int CAPACITY   = ILE_CAPACITY,
  parameter int DATA_WIDTH = ILE_DATA_WIDTH,
  localparam int IW        = $clog2(CAPACITY)
) (
  input  logic                  clk,
  input  store_ctl_t            ctl,
  input  logic [IW-1:0]         idx,
  input  logic [DATA_WIDTH-1:0] wr_data,
  output logic [DATA_WIDTH-1:0] rd_data
);

  logic [DATA_WIDTH-1:0] entries_r [CAPACITY];

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (ctl.ins) begin
        if (IW'(i) == idx) begin
          entries_r[i] <= wr_data;
        end else if (i > 0 && IW'(i) > idx) begin
          entries_r[i] <= entries_r[(i > 0) ? i - 1 : 0];
        end
      end else if (ctl.del) begin
        // last slot keeps its word; it lies beyond the count afterwards
        if (i < CAPACITY - 1 && IW'(i) >= idx) begin
          entries_r[i] <= entries_r[(i < CAPACITY - 1) ? i + 1 : i];
        end
      end
    end
  end

  assign rd_data = entries_r[idx];

endmodule

// ----- rtl/core/ile_ctrl.sv -----
// ----------------------------------------------------------------------------
// ile_ctrl
// Command decode, range and full checks, entry count register and result
// fields for one registered command.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ile_ctrl
  import ile_pkg::*;
#(
  parameter int CAPACITY   = ILE_CAPACITY,
  parameter int DATA_WIDTH = ILE_DATA_WIDTH,
  localparam int IW        = $clog2(CAPACITY),
  localparam int CW        = $clog2(CAPACITY + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_vld,
  input  logic [KIND_W-1:0]     cmd_kind,
  input  logic [POS_W-1:0]      cmd_pos,
  input  logic [DATA_WIDTH-1:0] rd_data,
  output store_ctl_t            st_ctl,
  output logic [IW-1:0]         st_idx,
  output status_t               res_status,
  output logic [VALUE_W-1:0]    res_read,
  output logic [COUNT_W-1:0]    res_count,
  output logic                  res_empty
);

  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  logic [CW-1:0] fill_r;
  logic [CW-1:0] fill_nxt;
  logic          full;
  logic          empty;
  logic          pos_ok;
  logic          rd_en;
  logic          clr;
  store_ctl_t    ctl;
  logic [IW-1:0] pos_idx;
  logic [IW-1:0] back_idx;

  assign full     = (fill_r == CW'(CAPACITY));
  assign empty    = (fill_r == '0);
  assign pos_ok   = (CMPW'(cmd_pos) < CMPW'(fill_r));
  assign pos_idx  = IW'(cmd_pos);
  assign back_idx = IW'(fill_r - CW'(1));

  always_comb begin
    ctl        = '0;
    st_idx     = '0;
    res_status = ST_OK;
    rd_en      = 1'b0;
    clr        = 1'b0;
    unique case (kind_t'(cmd_kind))
      KIND_PUSH_FRONT: begin
        if (full) res_status = ST_FULL;
        else ctl.ins = 1'b1;
      end
      KIND_PUSH_BACK: begin
        st_idx = IW'(fill_r);
        if (full) res_status = ST_FULL;
        else ctl.ins = 1'b1;
      end
      KIND_INSERT: begin
        st_idx = pos_idx;
        // insert at the head behaves as push front; range check first otherwise
        if (cmd_pos == '0) begin
          if (full) res_status = ST_FULL;
          else ctl.ins = 1'b1;
        end else if (!pos_ok) begin
          res_status = ST_RANGE;
        end else if (full) begin
          res_status = ST_FULL;
        end else begin
          ctl.ins = 1'b1;
        end
      end
      KIND_ERASE: begin
        st_idx = pos_idx;
        if (!pos_ok) res_status = ST_RANGE;
        else ctl.del = 1'b1;
      end
      KIND_POP_FRONT: begin
        if (empty) res_status = ST_RANGE;
        else ctl.del = 1'b1;
      end
      KIND_POP_BACK: begin
        st_idx = back_idx;
        if (empty) res_status = ST_RANGE;
        else ctl.del = 1'b1;
      end
      KIND_READ: begin
        st_idx = pos_idx;
        if (!pos_ok) res_status = ST_RANGE;
        else rd_en = 1'b1;
      end
      KIND_READ_FRONT: begin
        if (empty) res_status = ST_RANGE;
        else rd_en = 1'b1;
      end
      KIND_READ_BACK: begin
        st_idx = back_idx;
        if (empty) res_status = ST_RANGE;
        else rd_en = 1'b1;
      end
      KIND_CLEAR: begin
        clr = 1'b1;
      end
      default: begin
        res_status = ST_RANGE;
      end
    endcase
  end

  // drop store updates when no command is present
  assign st_ctl.ins = cmd_vld & ctl.ins;
  assign st_ctl.del = cmd_vld & ctl.del;

  always_comb begin
    fill_nxt = fill_r;
    priority if (!cmd_vld) fill_nxt = fill_r;
    else if (clr)          fill_nxt = '0;
    else if (ctl.ins)      fill_nxt = fill_r + CW'(1);
    else if (ctl.del)      fill_nxt = fill_r - CW'(1);
    else                   fill_nxt = fill_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  assign res_read  = rd_en ? VALUE_W'(rd_data) : '0;
  assign res_count = COUNT_W'(fill_nxt);
  assign res_empty = (fill_nxt == '0);

`include "indexed_list_engine_assert.svh"

  `ILE_ASSERT_NEVER(a_ins_and_del, st_ctl.ins && st_ctl.del)
  `ILE_ASSERT_NEVER(a_fill_bound, fill_r > CW'(CAPACITY))
  `ILE_ASSERT_IMPL(a_ins_not_full, st_ctl.ins, fill_r != CW'(CAPACITY))
  `ILE_ASSERT_IMPL(a_del_not_empty, st_ctl.del, fill_r != '0)
  `ILE_ASSERT_NEXT(a_clear_empties, cmd_vld && kind_t'(cmd_kind) == KIND_CLEAR, fill_r == '0)

endmodule

// ----- rtl/core/indexed_list_engine.sv -----
// ----------------------------------------------------------------------------
// indexed_list_engine
// The command is registered on acceptance and decoded from those registers;
// the result and out_valid are registered at the edge that ends decode.
// Throughput: one command per cycle; busy stays low and the receiver cannot
// stall. Synchronous reset empties the list; entries stay undefined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_list_engine
  import ile_pkg::*;
#(
  parameter int CAPACITY   = ILE_CAPACITY,
  parameter int DATA_WIDTH = ILE_DATA_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [POS_W-1:0]     in_position,
  input  logic [VALUE_W-1:0]   in_value,
  output logic                 out_valid,
  output logic [STATUS_W-1:0]  out_status,
  output logic [VALUE_W-1:0]   out_read_value,
  output logic [COUNT_W-1:0]   out_entry_count,
  output logic                 out_is_empty
);

  localparam int IW = $clog2(CAPACITY);

  logic                  cmd_vld_r;
  logic [KIND_W-1:0]     kind_r;
  logic [POS_W-1:0]      pos_r;
  logic [DATA_WIDTH-1:0] value_r;

  store_ctl_t            st_ctl;
  logic [IW-1:0]         st_idx;
  logic [DATA_WIDTH-1:0] rd_data;
  status_t               res_status;
  logic [VALUE_W-1:0]    res_read;
  logic [COUNT_W-1:0]    res_count;
  logic                  res_empty;

  // single-pass datapath: a new transaction fits every cycle
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
    end else begin
      cmd_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      kind_r  <= in_kind;
      pos_r   <= in_position;
      value_r <= DATA_WIDTH'(in_value);
    end
  end

  ile_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_vld    (cmd_vld_r),
    .cmd_kind   (kind_r),
    .cmd_pos    (pos_r),
    .rd_data    (rd_data),
    .st_ctl     (st_ctl),
    .st_idx     (st_idx),
    .res_status (res_status),
    .res_read   (res_read),
    .res_count  (res_count),
    .res_empty  (res_empty)
  );

  ile_store #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_store (
    .clk     (clk),
    .ctl     (st_ctl),
    .idx     (st_idx),
    .wr_data (value_r),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_vld_r) begin
      out_status      <= res_status;
      out_read_value  <= res_read;
      out_entry_count <= res_count;
      out_is_empty    <= res_empty;
    end
  end

endmodule

// ----- test/indexed_list_engine_test.sv -----
// ----------------------------------------------------------------------------
// indexed_list_engine_test
// Self-checking bench for the indexed list engine. A short table of directed
// commands covers empty and out-of-range cases, unknown codes and both
// extremes of the data word. Random traffic follows, mostly grow and drain
// runs with positions inside the list plus some raw noise, sent with several
// idle patterns. Results are checked against typed rows or a local predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module indexed_list_engine_test;
  import ile_pkg::*;

  localparam int          LIST_CAP      = ILE_CAPACITY;
  localparam logic [3:0]  KIND_UNUSED   = 4'd15;
  localparam int          PHASE_ITEMS   = 107;
  localparam int          END_WAIT_MAX  = 1000;

  typedef struct {
    status_t            status;
    logic [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
  } list_result_t;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] val;
    bit                 typed;
    list_result_t       res;
  } dir_row_t;

  logic                clk;
  logic                rst_n           = 1'b0;
  logic                start           = 1'b0;
  logic                busy;
  logic [KIND_W-1:0]   in_kind         = '0;
  logic [POS_W-1:0]    in_position     = '0;
  logic [VALUE_W-1:0]  in_value        = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [VALUE_W-1:0]  out_read_value;
  logic [COUNT_W-1:0]  out_entry_count;
  logic                out_is_empty;

  // Shadow copy of the list, owned by the driving process
  logic [VALUE_W-1:0]  list_words [LIST_CAP];
  int unsigned         list_fill;
  bit                  grow_mode;

  list_result_t        pending_results[$];
  dir_row_t            directed_rows[$];

  int unsigned mismatch_count = 0;
  int unsigned checked_count  = 0;
  int unsigned sent_count     = 0;
  int unsigned full_count     = 0;
  int unsigned range_count    = 0;
  int unsigned deepest_fill   = 0;

  indexed_list_engine DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Open a slot at p and shift later entries up
  function automatic void list_put(int unsigned p, logic [VALUE_W-1:0] w);
    for (int unsigned i = list_fill; i > p; i--) list_words[i] = list_words[i-1];
    list_words[p] = w;
    list_fill++;
  endfunction

  // Close the slot at p and shift later entries down
  function automatic void list_take(int unsigned p);
    for (int unsigned i = p; i + 1 < list_fill; i++) list_words[i] = list_words[i+1];
    list_fill--;
  endfunction

  function automatic list_result_t list_apply(logic [KIND_W-1:0] kind,
                                              logic [POS_W-1:0] pos,
                                              logic [VALUE_W-1:0] val);
    list_result_t r;
    int unsigned  p;
    r.status     = ST_OK;
    r.read_value = '0;
    p = pos;
    case (kind)
      KIND_PUSH_FRONT: begin
        if (list_fill >= LIST_CAP) r.status = ST_FULL;
        else list_put(0, val);
      end
      KIND_PUSH_BACK: begin
        if (list_fill >= LIST_CAP) r.status = ST_FULL;
        else list_put(list_fill, val);
      end
      KIND_INSERT: begin
        // position zero behaves as push front; otherwise range check first
        if (p == 0) begin
          if (list_fill >= LIST_CAP) r.status = ST_FULL;
          else list_put(0, val);
        end else if (p >= list_fill) begin
          r.status = ST_RANGE;
        end else if (list_fill >= LIST_CAP) begin
          r.status = ST_FULL;
        end else begin
          list_put(p, val);
        end
      end
      KIND_ERASE: begin
        if (p >= list_fill) r.status = ST_RANGE;
        else list_take(p);
      end
      KIND_POP_FRONT: begin
        if (list_fill == 0) r.status = ST_RANGE;
        else list_take(0);
      end
      KIND_POP_BACK: begin
        if (list_fill == 0) r.status = ST_RANGE;
        else list_take(list_fill - 1);
      end
      KIND_READ: begin
        if (p >= list_fill) r.status = ST_RANGE;
        else r.read_value = list_words[p];
      end
      KIND_READ_FRONT: begin
        if (list_fill == 0) r.status = ST_RANGE;
        else r.read_value = list_words[0];
      end
      KIND_READ_BACK: begin
        if (list_fill == 0) r.status = ST_RANGE;
        else r.read_value = list_words[list_fill-1];
      end
      KIND_CLEAR: begin
        list_fill = 0;
      end
      default: begin
        r.status = ST_RANGE;
      end
    endcase
    r.entry_count = COUNT_W'(list_fill);
    r.is_empty    = (list_fill == 0);
    if (r.status == ST_FULL) full_count++;
    if (r.status == ST_RANGE) range_count++;
    if (list_fill > deepest_fill) deepest_fill = list_fill;
    return r;
  endfunction

  function automatic dir_row_t drow(logic [KIND_W-1:0] k, logic [POS_W-1:0] p,
                                    logic [VALUE_W-1:0] v, bit typed = 1'b0,
                                    status_t st = ST_OK, logic [VALUE_W-1:0] rv = '0,
                                    logic [COUNT_W-1:0] cnt = '0);
    dir_row_t row;
    row.kind  = k;
    row.pos   = p;
    row.val   = v;
    row.typed = typed;
    row.res   = '{st, rv, cnt, (cnt == 0)};
    return row;
  endfunction

  // Append one row to the directed table
  function automatic void add_row(dir_row_t row);
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Drive one transaction, wait for acceptance and record what it must return
  task automatic send_command(logic [KIND_W-1:0] kind, logic [POS_W-1:0] pos,
                              logic [VALUE_W-1:0] val, bit typed,
                              list_result_t typed_res, int unsigned idle_pct);
    list_result_t predicted;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    in_kind     <= kind;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (busy);
    predicted = list_apply(kind, pos, val);
    pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
    sent_count++;
  endtask

  // Pick a command: mostly grow or drain runs aimed inside the list, some noise
  task automatic pick_command(output logic [KIND_W-1:0] kind,
                              output logic [POS_W-1:0] pos,
                              output logic [VALUE_W-1:0] val);
    int unsigned r;
    val = $urandom();
    if (list_fill == 0) grow_mode = 1'b1;
    else if (list_fill == LIST_CAP && $urandom_range(3) == 0) grow_mode = 1'b0;
    else if ($urandom_range(24) == 0) grow_mode = ~grow_mode;

    if ($urandom_range(99) < 20) begin
      kind = KIND_W'($urandom_range(15));
      pos  = POS_W'($urandom_range(31));
      return;
    end

    r = $urandom_range(99);
    if (r < 2) begin
      kind = KIND_CLEAR;
    end else if (grow_mode) begin
      if (r < 27) kind = KIND_PUSH_FRONT;
      else if (r < 52) kind = KIND_PUSH_BACK;
      else if (r < 72) kind = KIND_INSERT;
      else if (r < 90) kind = KIND_W'(KIND_READ + $urandom_range(2));
      else kind = KIND_W'(KIND_ERASE + $urandom_range(2));
    end else begin
      if (r < 27) kind = KIND_ERASE;
      else if (r < 47) kind = KIND_POP_FRONT;
      else if (r < 67) kind = KIND_POP_BACK;
      else if (r < 87) kind = KIND_W'(KIND_READ + $urandom_range(2));
      else kind = KIND_W'(KIND_PUSH_FRONT + $urandom_range(2));
    end

    // insert may also hit position count, which is rejected unless the list is empty
    if (kind == KIND_INSERT) pos = POS_W'($urandom_range(list_fill));
    else if (list_fill > 0) pos = POS_W'($urandom_range(list_fill - 1));
    else pos = POS_W'($urandom_range(31));
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result strobe with no command outstanding");
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        checked_count++;
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_status, want.status));
        if (out_read_value !== want.read_value)
          report_mismatch($sformatf("read_value %h, want %h", out_read_value,
                                    want.read_value));
        if (out_entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, want %0d", out_entry_count,
                                    want.entry_count));
        if (out_is_empty !== want.is_empty)
          report_mismatch($sformatf("is_empty %0b, want %0b", out_is_empty,
                                    want.is_empty));
      end
    end
  end

  initial begin
    logic [KIND_W-1:0]  kind;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] val;
    int unsigned        idle_pct [4];
    int unsigned        done_items;
    int unsigned        waited;
    dir_row_t           row;

    idle_pct  = '{0, 87, 0, 32};
    list_fill = 0;
    grow_mode = 1'b1;
    foreach (list_words[i]) list_words[i] = '0;

    // empty-list errors first, then small pushes, reads and the insert corner cases
    add_row(drow(KIND_READ_FRONT, 0, '0, 1, ST_RANGE, '0, 0));
    add_row(drow(KIND_POP_FRONT, 0, '0, 1, ST_RANGE, '0, 0));
    add_row(drow(KIND_POP_BACK, 0, '0, 1, ST_RANGE, '0, 0));
    add_row(drow(KIND_READ_BACK, 0, '0, 1, ST_RANGE, '0, 0));
    add_row(drow(KIND_READ, 0, '0, 1, ST_RANGE, '0, 0));
    add_row(drow(KIND_ERASE, 31, '0, 1, ST_RANGE, '0, 0));
    add_row(drow(KIND_INSERT, 5, 32'h1234_5678, 1, ST_RANGE, '0, 0));
    add_row(drow(KIND_INSERT, 0, 32'hFFFF_FFFF, 1, ST_OK, '0, 1));
    add_row(drow(KIND_PUSH_BACK, 31, 32'h0000_0000, 1, ST_OK, '0, 2));
    add_row(drow(KIND_READ, 0, '0, 1, ST_OK, 32'hFFFF_FFFF, 2));
    add_row(drow(KIND_PUSH_FRONT, 0, 32'hA5A5_A5A5));
    add_row(drow(KIND_READ, 1, '0));
    add_row(drow(KIND_INSERT, 3, 32'hDEAD_BEEF, 1, ST_RANGE, '0, 3));
    add_row(drow(KIND_INSERT, 1, 32'h5A5A_5A5A));
    add_row(drow(KIND_READ_FRONT, 0, '0));
    add_row(drow(KIND_READ_BACK, 0, '0));
    add_row(drow(KIND_ERASE, 1, '0));
    add_row(drow(KIND_READ, 31, '0, 1, ST_RANGE, '0, 3));
    add_row(drow(KIND_UNUSED, 31, 32'hFFFF_FFFF, 1, ST_RANGE, '0, 3));
    add_row(drow(KIND_POP_BACK, 0, '0));
    add_row(drow(KIND_POP_FRONT, 0, '0));
    add_row(drow(KIND_CLEAR, 0, '0, 1, ST_OK, '0, 0));
    add_row(drow(KIND_CLEAR, 0, '0, 1, ST_OK, '0, 0));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_command(row.kind, row.pos, row.val, row.typed, row.res, 0);
    end

    for (int ph = 0; ph < 4; ph++) begin
      // hold off until every outstanding result has come back
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      done_items = 0;
      while (done_items < PHASE_ITEMS) begin
        pick_command(kind, pos, val);
        send_command(kind, pos, val, 1'b0, '{ST_OK, '0, '0, 1'b0}, idle_pct[ph]);
        done_items++;
      end
    end

    start <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < END_WAIT_MAX) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    repeat (8) @(posedge clk);

    $display("Sent %0d commands (%0d directed); %0d results checked", sent_count,
             directed_rows.size(), checked_count);
    $display("Full rejections %0d, range errors %0d, deepest fill %0d of %0d",
             full_count, range_count, deepest_fill, LIST_CAP);
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/ile_pkg.sv
rtl/core/ile_store.sv
rtl/core/ile_ctrl.sv
rtl/core/indexed_list_engine.sv
test/indexed_list_engine_test.sv
